// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define SBPD_ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// expression must never be true out of reset
`define SBPD_ASSERT_NEVER(label, clk, rst_n, expr) \
	`SBPD_ASSERT_PROP(label, clk, rst_n, !(expr))

`else

`define SBPD_ASSERT_PROP(label, clk, rst_n, prop)
`define SBPD_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// File: rtl/sbpd_pkg.sv
// ----------------------------------------------------------------------------
// sbpd_pkg
// shared types, constants and helper functions of the boundary pixel detector
// ----------------------------------------------------------------------------
package sbpd_pkg;

	localparam int unsigned DEF_MAX_WIDTH  = 1024;
	localparam int unsigned DEF_MAX_HEIGHT = 1024;
	localparam int unsigned DEF_COUNT_BITS = 16;

	localparam int unsigned SIZE_BITS      = 11;
	localparam int unsigned LIMIT_BITS     = 16;
	localparam int unsigned CFG_DATA_BITS  = 16;
	localparam int unsigned CFG_INDEX_BITS = 2;
	localparam int unsigned QUEUE_DEPTH    = 4;

	localparam logic [SIZE_BITS-1:0]  SIZE_RESET  = 11'd1024;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd255;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_LIMIT  = 2'd2
	} cfg_reg_t;

	localparam logic [1:0] CLS_NONE    = 2'b00;
	localparam logic [1:0] CLS_INSIDE  = 2'b01;
	localparam logic [1:0] CLS_OUTSIDE = 2'b10;

	// result slots of one pixel, emitted lowest first
	localparam int unsigned SLOT_UP_LEFT  = 0;   // (c-1, r-1)
	localparam int unsigned SLOT_UP_HERE  = 1;   // (c,   r-1)
	localparam int unsigned SLOT_CUR_LEFT = 2;   // (c-1, r)
	localparam int unsigned SLOT_CUR_HERE = 3;   // (c,   r)
	localparam int unsigned NUM_SLOTS     = 4;

	typedef struct packed {
		logic [NUM_SLOTS-1:0] mask;
		logic [NUM_SLOTS-1:0] on_edge;
	} emit_t;

	localparam int unsigned EMIT_BITS = $bits(emit_t);

	// last valid index for a size register: zero acts as one, above max acts as max
	function automatic int unsigned clamp_last(logic [SIZE_BITS-1:0] v, int unsigned maxv);
		int unsigned x;
		x = 32'(v);
		if (x == 0)
			return 0;
		if (x > maxv)
			return maxv - 1;
		return x - 1;
	endfunction

	// edge decision for one window position; rows/cols clamped via top and left
	function automatic logic edge_at(logic [17:0] win, logic [1:0] wr, logic [1:0] wc,
			logic [1:0] top, logic [1:0] left);
		logic [1:0]  rows [3];
		logic [1:0]  cols [3];
		logic        hit;
		int unsigned idx;
		int unsigned i;
		int unsigned j;
		rows[0] = top;
		rows[1] = wr;
		rows[2] = 2'd2;
		cols[0] = left;
		cols[1] = wc;
		cols[2] = 2'd2;
		hit = 1'b0;
		for (i = 0; i < 3; i++) begin
			for (j = 0; j < 3; j++) begin
				idx = 32'(rows[i]) * 3 + 32'(cols[j]);
				hit = hit | win[2 * idx + 1];
			end
		end
		idx = 32'(wr) * 3 + 32'(wc);
		return win[2 * idx] & hit;
	endfunction

endpackage

// File: rtl/sbpd_ram.sv
// ----------------------------------------------------------------------------
// sbpd_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sbpd_ram #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/sbpd_front.sv
// ----------------------------------------------------------------------------
// sbpd_front
// pixel intake: raster position, classing, line store and 3x3 class window
// ----------------------------------------------------------------------------
module sbpd_front import sbpd_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int unsigned COUNT_BITS = DEF_COUNT_BITS,
	localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int unsigned ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
	localparam int unsigned QW    = EMIT_BITS + COL_W + ROW_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pixel_valid,
	output logic                  pixel_stall,
	input  logic [COUNT_BITS-1:0] iteration_count,
	input  logic [COL_W-1:0]      wlast,
	input  logic [ROW_W-1:0]      hlast,
	input  logic [COUNT_BITS-1:0] limit,
	output logic                  q_push,
	output logic [QW-1:0]         q_entry,
	input  logic                  q_full
);

	logic [COL_W-1:0] col_q, c0, col_nx;
	logic [ROW_W-1:0] row_q, r0, row_nx;
	logic             restart;
	logic             accept;
	logic             s1_leave;
	logic [1:0]       cls;

	logic             valid_s1;
	logic [COL_W-1:0] c_s1;
	logic [ROW_W-1:0] r_s1;
	logic [1:0]       cls_s1;
	logic             r_ge1_s1, r_ge2_s1, c_ge1_s1, c_last_s1, r_last_s1;
	logic [1:0]       top_up_s1, top_cur_s1, left_a_s1, left_b_s1;
	logic             byp_s1;
	logic [3:0]       byp_data_s1;

	logic [3:0]       rd_data;
	logic [3:0]       line_entry;
	logic [3:0]       wr_data;
	logic [1:0]       up1, up2;
	logic [17:0]      win_q, win_nx;
	emit_t            emit;

	// a size change can leave the position outside the frame: restart at the origin
	assign restart  = (col_q > wlast) || (row_q > hlast);
	assign c0       = restart ? '0 : col_q;
	assign r0       = restart ? '0 : row_q;

	assign pixel_stall = valid_s1 && q_full;
	assign accept      = pixel_valid && !pixel_stall;
	assign s1_leave    = valid_s1 && !q_full;

	always_comb begin
		if (iteration_count == limit)
			cls = CLS_INSIDE;
		else if (iteration_count < limit)
			cls = CLS_OUTSIDE;
		else
			cls = CLS_NONE;
	end

	always_comb begin
		if (c0 == wlast) begin
			col_nx = '0;
			row_nx = (r0 == hlast) ? '0 : r0 + ROW_W'(1);
		end else begin
			col_nx = c0 + COL_W'(1);
			row_nx = r0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				col_q <= col_nx;
				row_q <= row_nx;
			end
			if (accept)
				valid_s1 <= 1'b1;
			else if (s1_leave)
				valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_s1        <= c0;
			r_s1        <= r0;
			cls_s1      <= cls;
			r_ge1_s1    <= (r0 != '0);
			r_ge2_s1    <= (r0 > ROW_W'(1));
			c_ge1_s1    <= (c0 != '0);
			c_last_s1   <= (c0 == wlast);
			r_last_s1   <= (r0 == hlast);
			top_up_s1   <= (r0 == ROW_W'(1)) ? 2'd1 : 2'd0;
			top_cur_s1  <= (r0 == '0) ? 2'd2 : 2'd1;
			left_a_s1   <= (c0 == COL_W'(1)) ? 2'd1 : 2'd0;
			left_b_s1   <= (c0 == '0) ? 2'd2 : 2'd1;
			// same entry written in this cycle: the ram read returns the old word
			byp_s1      <= s1_leave && (c_s1 == c0);
			byp_data_s1 <= wr_data;
		end
	end

	// line store word: [1:0] row above, [3:2] two rows above
	sbpd_ram #(
		.WIDTH (4),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (s1_leave),
		.waddr (c_s1),
		.wdata (wr_data),
		.re    (accept),
		.raddr (c0),
		.rdata (rd_data)
	);

	assign line_entry = byp_s1 ? byp_data_s1 : rd_data;
	assign up1        = r_ge1_s1 ? line_entry[1:0] : CLS_NONE;
	assign up2        = r_ge2_s1 ? line_entry[3:2] : CLS_NONE;
	assign wr_data    = {up1, cls_s1};

	always_comb begin
		logic [1:0] fresh [3];
		fresh[0] = up2;
		fresh[1] = up1;
		fresh[2] = cls_s1;
		for (int k = 0; k < 3; k++) begin
			win_nx[6*k +: 2]     = win_q[6*k + 2 +: 2];
			win_nx[6*k + 2 +: 2] = win_q[6*k + 4 +: 2];
			win_nx[6*k + 4 +: 2] = fresh[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			win_q <= '0;
		else if (s1_leave)
			win_q <= win_nx;
	end

	always_comb begin
		emit.mask[SLOT_UP_LEFT]     = r_ge1_s1 && c_ge1_s1;
		emit.mask[SLOT_UP_HERE]     = r_ge1_s1 && c_last_s1;
		emit.mask[SLOT_CUR_LEFT]    = r_last_s1 && c_ge1_s1;
		emit.mask[SLOT_CUR_HERE]    = r_last_s1 && c_last_s1;
		emit.on_edge[SLOT_UP_LEFT]  = edge_at(win_nx, 2'd1, 2'd1, top_up_s1, left_a_s1);
		emit.on_edge[SLOT_UP_HERE]  = edge_at(win_nx, 2'd1, 2'd2, top_up_s1, left_b_s1);
		emit.on_edge[SLOT_CUR_LEFT] = edge_at(win_nx, 2'd2, 2'd1, top_cur_s1, left_a_s1);
		emit.on_edge[SLOT_CUR_HERE] = edge_at(win_nx, 2'd2, 2'd2, top_cur_s1, left_b_s1);
	end

	// pixels with no result (first row or first column, unless it is also the last) never enter the queue
	assign q_push  = s1_leave && (emit.mask != '0);
	assign q_entry = {r_s1, c_s1, emit};

endmodule

// File: rtl/sbpd_queue.sv
// ----------------------------------------------------------------------------
// sbpd_queue
// small register fifo between pixel intake and result output
// ----------------------------------------------------------------------------
module sbpd_queue import sbpd_pkg::*; #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = QUEUE_DEPTH,
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [PW:0]      cnt_q;

	assign full  = (cnt_q == (PW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (PW+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (PW+1)'(1);
		end
	end

endmodule

// File: rtl/sbpd_back.sv
// ----------------------------------------------------------------------------
// sbpd_back
// result sequencer: walks the slots of each queued pixel into the output register
// ----------------------------------------------------------------------------
module sbpd_back import sbpd_pkg::*; #(
	parameter int unsigned COL_W = 10,
	parameter int unsigned ROW_W = 10,
	localparam int unsigned QW = EMIT_BITS + COL_W + ROW_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  logic [QW-1:0]    q_entry,
	output logic             q_pop,
	output logic             result_valid,
	input  logic             result_stall,
	output logic [COL_W-1:0] column,
	output logic [ROW_W-1:0] row,
	output logic             on_edge,
	output logic             last
);

	emit_t                e_emit;
	logic [COL_W-1:0]     e_col;
	logic [ROW_W-1:0]     e_row;

	logic [NUM_SLOTS-1:0] cur_mask_q, cur_edge_q;
	logic [COL_W-1:0]     cur_col_q;
	logic [ROW_W-1:0]     cur_row_q;
	logic [NUM_SLOTS-1:0] sel, rest;
	logic                 out_free, take, cur_done;

	logic                 valid_q;
	logic [COL_W-1:0]     column_q;
	logic [ROW_W-1:0]     row_q;
	logic                 on_edge_q, last_q;

	assign e_emit = q_entry[EMIT_BITS-1:0];
	assign e_col  = q_entry[EMIT_BITS +: COL_W];
	assign e_row  = q_entry[EMIT_BITS + COL_W +: ROW_W];

	// lowest pending slot
	assign sel      = cur_mask_q & (~cur_mask_q + NUM_SLOTS'(1));
	assign rest     = cur_mask_q & ~sel;
	assign out_free = !valid_q || !result_stall;
	assign take     = out_free && (cur_mask_q != '0);
	assign cur_done = (cur_mask_q == '0) || (take && (rest == '0));
	assign q_pop    = !q_empty && cur_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mask_q <= '0;
			valid_q    <= 1'b0;
		end else begin
			if (q_pop)
				cur_mask_q <= e_emit.mask;
			else if (take)
				cur_mask_q <= rest;
			if (take)
				valid_q <= 1'b1;
			else if (!result_stall)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_edge_q <= e_emit.on_edge;
			cur_col_q  <= e_col;
			cur_row_q  <= e_row;
		end
		if (take) begin
			column_q  <= (sel[SLOT_UP_LEFT] || sel[SLOT_CUR_LEFT]) ?
					cur_col_q - COL_W'(1) : cur_col_q;
			row_q     <= (sel[SLOT_UP_LEFT] || sel[SLOT_UP_HERE]) ?
					cur_row_q - ROW_W'(1) : cur_row_q;
			on_edge_q <= |(sel & cur_edge_q);
			last_q    <= (rest == '0);
		end
	end

	assign result_valid = valid_q;
	assign column       = column_q;
	assign row          = row_q;
	assign on_edge      = on_edge_q;
	assign last         = last_q;

endmodule

// File: rtl/set_boundary_pixel_detect.sv
// ----------------------------------------------------------------------------
// set_boundary_pixel_detect
// eight-neighbour boundary detection over a raster stream of iteration counts
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order and reports, per pixel, whether it
// is inside the set with an outside pixel among its eight clamped neighbours.
// Results come out once a pixel's neighbourhood is complete, in raster order
// but on the last row, where the last two rows interleave: one per pixel from
// the second row on, and up to four for the last pixel of a frame, which leave
// the output one per clock while not stalled. Sustained rate is one pixel per
// cycle; the intake holds off only when the four-entry result queue is full,
// which happens when the output side stalls or on the last row of a frame,
// where each pixel but the first yields two or more results. Path: line store
// read, queue, slot sequencer, output register. The line store is one ram of
// MAX_WIDTH words, one read and one write per cycle, needs no clearing at reset.
// Users write configuration only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module set_boundary_pixel_detect import sbpd_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int unsigned COUNT_BITS = DEF_COUNT_BITS,
	localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int unsigned ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      pixel_valid,
	output logic                      pixel_stall,
	input  logic [COUNT_BITS-1:0]     iteration_count,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic [COL_W-1:0]          column,
	output logic [ROW_W-1:0]          row,
	output logic                      on_edge,
	output logic                      last
);

	localparam int unsigned QW = EMIT_BITS + COL_W + ROW_W;

	logic [COL_W-1:0]      wlast_q;
	logic [ROW_W-1:0]      hlast_q;
	logic [COUNT_BITS-1:0] limit_q;

	logic                  q_push, q_pop, q_full, q_empty;
	logic [QW-1:0]         q_wdata, q_rdata;

	// sizes are kept as clamped last index, the limit already cut to COUNT_BITS
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= COL_W'(clamp_last(SIZE_RESET, MAX_WIDTH));
			hlast_q <= ROW_W'(clamp_last(SIZE_RESET, MAX_HEIGHT));
			limit_q <= COUNT_BITS'(LIMIT_RESET);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_WIDTH: begin
					wlast_q <= COL_W'(clamp_last(cfg_data[SIZE_BITS-1:0], MAX_WIDTH));
				end
				REG_HEIGHT: begin
					hlast_q <= ROW_W'(clamp_last(cfg_data[SIZE_BITS-1:0], MAX_HEIGHT));
				end
				REG_LIMIT: begin
					limit_q <= COUNT_BITS'(cfg_data[LIMIT_BITS-1:0]);
				end
				default: ;
			endcase
		end
	end

	sbpd_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.pixel_valid     (pixel_valid),
		.pixel_stall     (pixel_stall),
		.iteration_count (iteration_count),
		.wlast           (wlast_q),
		.hlast           (hlast_q),
		.limit           (limit_q),
		.q_push          (q_push),
		.q_entry         (q_wdata),
		.q_full          (q_full)
	);

	sbpd_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	sbpd_back #(
		.COL_W (COL_W),
		.ROW_W (ROW_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_entry      (q_rdata),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.column       (column),
		.row          (row),
		.on_edge      (on_edge),
		.last         (last)
	);

	// intake must never overrun the result queue
	`SBPD_ASSERT_NEVER(a_no_push_when_full, clk, arst_n, q_push && q_full)

	// results of one pixel leave back to back once the first is taken
	`SBPD_ASSERT_PROP(a_group_no_gap, clk, arst_n,
		result_valid && !result_stall && !last |=> result_valid)

	// the queue is only drained into the sequencer when it holds something
	`SBPD_ASSERT_NEVER(a_no_pop_when_empty, clk, arst_n, q_pop && q_empty)

endmodule
